// ===== rtl/srd_pkg.sv =====
package srd_pkg;

    // fixed-point format of strengths and results
    localparam int FRAC_BITS = 15;

    localparam int STR_W    = 16;
    localparam int OUT_W    = 17;
    localparam int DZ_W     = 16;
    localparam int D4_W     = DZ_W + 2;             // deadzone with two extra fraction bits
    localparam int SQR_W    = 2 * STR_W;
    localparam int DSQ_W    = 2 * D4_W;
    localparam int LEN2_W   = SQR_W + 1;
    localparam int ROOT_W   = 31;                   // floor(sqrt(len2 * 2^28))
    localparam int SQ_PAD   = 28;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int SQ_REM_W = ROOT_W + 2;
    localparam int DZL_SH   = 12;
    localparam int DZL_W    = FRAC_BITS + 15;
    localparam int Q_W      = 18;                   // quotient bits of both dividers
    localparam int PROD_W   = STR_W + Q_W;
    localparam int D2_SH    = FRAC_BITS - 3;
    localparam int D1_REM_W = DZL_W;
    localparam int D2_REM_W = ROOT_W;

    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = Q_W;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_USE_EXPLICIT = 3'd0;
    localparam logic [2:0] REG_EXPLICIT_DZ  = 3'd1;
    localparam logic [2:0] REG_DZ_POS_X     = 3'd2;
    localparam logic [2:0] REG_DZ_NEG_X     = 3'd3;
    localparam logic [2:0] REG_DZ_POS_Y     = 3'd4;
    localparam logic [2:0] REG_DZ_NEG_Y     = 3'd5;

    localparam logic [DZ_W-1:0]   DZ_RESET = DZ_W'(16384);
    localparam logic [LEN2_W-1:0] ONE_SQ   = LEN2_W'(1) << (2 * FRAC_BITS);
    localparam logic [DZL_W-1:0]  ONE_L    = DZL_W'(1) << (FRAC_BITS + 14);
    localparam logic [Q_W-1:0]    R_UNIT   = Q_W'(1) << 17;

    // per-item side data traveling down the pipe
    typedef struct packed {
        logic                negx;
        logic                negy;
        logic [STR_W-1:0]    ax;
        logic [STR_W-1:0]    ay;
        logic [D4_W-1:0]     d4;
        logic [ROOT_W-1:0]   root;
        logic                unit;
        logic                zero;
    } t_side;

endpackage

// ===== rtl/stick_radial_deadzone.sv =====
// Pipeline: 74 register stages between the input transaction and the result on o_out_*.
// Throughput: one transaction per cycle; a 31-step square root and two 18-step
//   restoring dividers are fully unrolled, one step per pipeline stage.
// A stalled output freezes the whole pipe; o_in_ready = !o_out_valid | i_out_ready.
// Reset (i_rst_n low, synchronous) clears all valid bits and restores the
//   deadzone registers to their defaults; data registers are not reset.
module stick_radial_deadzone (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srd_pkg::ADDR_W-1:0]   paddr,
    input  logic [srd_pkg::DATA_W-1:0]   pwdata,
    output logic [srd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [srd_pkg::STR_W-1:0]    i_strength_pos_x,
    input  logic [srd_pkg::STR_W-1:0]    i_strength_neg_x,
    input  logic [srd_pkg::STR_W-1:0]    i_strength_pos_y,
    input  logic [srd_pkg::STR_W-1:0]    i_strength_neg_y,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [srd_pkg::OUT_W-1:0] o_out_x,
    output logic signed [srd_pkg::OUT_W-1:0] o_out_y
);
    import srd_pkg::*;

    // Stage map:
    //   A      : axis differences, magnitudes, signs, deadzone select
    //   B      : squares (x^2, y^2, d4^2)
    //   C      : len2 sum
    //   D      : dead / unit tests
    //   SQ0..  : 31 digit-by-digit square root steps
    //   E      : scale numerator / denominator, degenerate checks
    //   D1..   : 18 steps of ratio divide r = num*2^17/den
    //   M      : magnitude times ratio (unit case forces r = 1.0)
    //   D2..   : 18 steps of final divide by root, x and y lanes in parallel
    //   F      : sign restore, output register
    localparam int ST_A   = 0;
    localparam int ST_B   = 1;
    localparam int ST_C   = 2;
    localparam int ST_D   = 3;
    localparam int ST_SQ0 = 4;
    localparam int ST_E   = ST_SQ0 + SQ_STEPS;
    localparam int ST_D1  = ST_E + 1;
    localparam int ST_M   = ST_D1 + DIV_STEPS;
    localparam int ST_D2  = ST_M + 1;
    localparam int ST_F   = ST_D2 + DIV_STEPS;
    localparam int N_STG  = ST_F + 1;

    // ---------------- configuration port ----------------
    logic              r_use_explicit;
    logic [DZ_W-1:0]   r_explicit_dz;
    logic [DZ_W-1:0]   r_dz_pos_x;
    logic [DZ_W-1:0]   r_dz_neg_x;
    logic [DZ_W-1:0]   r_dz_pos_y;
    logic [DZ_W-1:0]   r_dz_neg_y;
    logic              w_cfg_wr;
    logic [2:0]        w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_explicit <= 1'b0;
            r_explicit_dz  <= DZ_RESET;
            r_dz_pos_x     <= DZ_RESET;
            r_dz_neg_x     <= DZ_RESET;
            r_dz_pos_y     <= DZ_RESET;
            r_dz_neg_y     <= DZ_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_USE_EXPLICIT: r_use_explicit <= pwdata[0];
                REG_EXPLICIT_DZ:  r_explicit_dz  <= pwdata[DZ_W-1:0];
                REG_DZ_POS_X:     r_dz_pos_x     <= pwdata[DZ_W-1:0];
                REG_DZ_NEG_X:     r_dz_neg_x     <= pwdata[DZ_W-1:0];
                REG_DZ_POS_Y:     r_dz_pos_y     <= pwdata[DZ_W-1:0];
                REG_DZ_NEG_Y:     r_dz_neg_y     <= pwdata[DZ_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_USE_EXPLICIT: prdata = DATA_W'(r_use_explicit);
            REG_EXPLICIT_DZ:  prdata = DATA_W'(r_explicit_dz);
            REG_DZ_POS_X:     prdata = DATA_W'(r_dz_pos_x);
            REG_DZ_NEG_X:     prdata = DATA_W'(r_dz_neg_x);
            REG_DZ_POS_Y:     prdata = DATA_W'(r_dz_pos_y);
            REG_DZ_NEG_Y:     prdata = DATA_W'(r_dz_neg_y);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Single enable for every stage: the pipe moves unless the output is held.
    logic              w_en;
    logic [N_STG-1:0]  r_vld;

    assign w_en        = !r_vld[ST_F] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[ST_F];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STG-2:0], i_in_valid};
        end
    end

    // ---------------- side data ----------------
    t_side r_sb [ST_F];
    t_side n_sb [ST_F];

    logic [LEN2_W-1:0]  r_len2;
    logic [LEN2_W-1:0]  r_len2_d;
    logic [DSQ_W-1:0]   r_dsq;
    logic [DSQ_W-1:0]   r_dsq_c;
    logic [SQR_W-1:0]   r_sqx;
    logic [SQR_W-1:0]   r_sqy;

    logic [ROOT_W-1:0]   r_sq_res [SQ_STEPS];
    logic [SQ_REM_W-1:0] r_sq_rem [SQ_STEPS];
    logic [RAD_W-1:0]    r_sq_rad [SQ_STEPS];

    logic [DZL_W-1:0]    w_dzl;
    logic [DZL_W-1:0]    r_num;
    logic [DZL_W-1:0]    r_den;

    always_comb begin
        logic               negx;
        logic               negy;
        logic [D4_W-1:0]    d4;
        logic [ROOT_W-1:0]  root;
        for (int s = 1; s < ST_F; s++) begin
            n_sb[s] = r_sb[s-1];
        end
        // stage A: signed differences as sign plus magnitude
        negx = i_strength_neg_x > i_strength_pos_x;
        negy = i_strength_neg_y > i_strength_pos_y;
        if (r_use_explicit) begin
            d4 = {r_explicit_dz, 2'b00};
        end else begin
            d4 = D4_W'(r_dz_pos_x) + D4_W'(r_dz_neg_x) + D4_W'(r_dz_pos_y) + D4_W'(r_dz_neg_y);
        end
        n_sb[ST_A].negx = negx;
        n_sb[ST_A].negy = negy;
        n_sb[ST_A].ax   = negx ? i_strength_neg_x - i_strength_pos_x
                               : i_strength_pos_x - i_strength_neg_x;
        n_sb[ST_A].ay   = negy ? i_strength_neg_y - i_strength_pos_y
                               : i_strength_pos_y - i_strength_neg_y;
        n_sb[ST_A].d4   = d4;
        n_sb[ST_A].root = '0;
        n_sb[ST_A].unit = 1'b0;
        n_sb[ST_A].zero = 1'b0;
        // stage D: dead test 16*len2 <= d4^2, unit test len2 > 1.0
        n_sb[ST_D].zero = {1'b0, r_len2, 4'b0000} <= (DSQ_W + 2)'(r_dsq_c);
        n_sb[ST_D].unit = r_len2 > ONE_SQ;
        // stage E: root lands in side data, degenerate cases fold into zero
        root = r_sq_res[SQ_STEPS-1];
        n_sb[ST_E].root = root;
        n_sb[ST_E].zero = r_sb[ST_E-1].zero || (root == '0)
                       || (!r_sb[ST_E-1].unit && (w_dzl >= ONE_L));
    end

    assign w_dzl = DZL_W'(r_sb[ST_E-1].d4) << DZL_SH;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < ST_F; s++) begin
                r_sb[s] <= n_sb[s];
            end
            r_sqx    <= r_sb[ST_A].ax * r_sb[ST_A].ax;
            r_sqy    <= r_sb[ST_A].ay * r_sb[ST_A].ay;
            r_dsq    <= r_sb[ST_A].d4 * r_sb[ST_A].d4;
            r_len2   <= LEN2_W'(r_sqx) + LEN2_W'(r_sqy);
            r_dsq_c  <= r_dsq;
            r_len2_d <= r_len2;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [ROOT_W-1:0]   n_sq_res [SQ_STEPS];
    logic [SQ_REM_W-1:0] n_sq_rem [SQ_STEPS];
    logic [RAD_W-1:0]    n_sq_rad [SQ_STEPS];

    always_comb begin
        logic [ROOT_W-1:0]   res_in;
        logic [SQ_REM_W-1:0] rem_in;
        logic [RAD_W-1:0]    rad_in;
        logic [SQ_REM_W+1:0] t;
        logic [SQ_REM_W+1:0] trial;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                res_in = '0;
                rem_in = '0;
                rad_in = {1'b0, r_len2_d, {SQ_PAD{1'b0}}};
            end else begin
                res_in = r_sq_res[k-1];
                rem_in = r_sq_rem[k-1];
                rad_in = r_sq_rad[k-1];
            end
            t     = {rem_in, rad_in[RAD_W-1 -: 2]};
            trial = (SQ_REM_W + 2)'({res_in, 2'b01});
            if (t >= trial) begin
                n_sq_rem[k] = SQ_REM_W'(t - trial);
                n_sq_res[k] = {res_in[ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_rem[k] = SQ_REM_W'(t);
                n_sq_res[k] = {res_in[ROOT_W-2:0], 1'b0};
            end
            n_sq_rad[k] = rad_in << 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_sq_res[k] <= n_sq_res[k];
                r_sq_rem[k] <= n_sq_rem[k];
                r_sq_rad[k] <= n_sq_rad[k];
            end
        end
    end

    // ---------------- stage E: ratio operands ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= (r_sq_res[SQ_STEPS-1] > ROOT_W'(w_dzl))
                   ? DZL_W'(r_sq_res[SQ_STEPS-1] - ROOT_W'(w_dzl)) : '0;
            r_den <= ONE_L - w_dzl;
        end
    end

    // ---------------- divider 1: r = num * 2^17 / den ----------------
    logic [D1_REM_W-1:0] r_d1_rem [DIV_STEPS];
    logic [Q_W-1:0]      r_d1_lo  [DIV_STEPS];
    logic [Q_W-1:0]      r_d1_q   [DIV_STEPS];
    logic [DZL_W-1:0]    r_d1_den [DIV_STEPS];
    logic [D1_REM_W-1:0] n_d1_rem [DIV_STEPS];
    logic [Q_W-1:0]      n_d1_lo  [DIV_STEPS];
    logic [Q_W-1:0]      n_d1_q   [DIV_STEPS];
    logic [DZL_W-1:0]    n_d1_den [DIV_STEPS];

    always_comb begin
        logic [D1_REM_W-1:0] rem_in;
        logic [Q_W-1:0]      lo_in;
        logic [Q_W-1:0]      q_in;
        logic [DZL_W-1:0]    den_in;
        logic [D1_REM_W:0]   t;
        logic                ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                rem_in = r_num >> 1;
                lo_in  = {r_num[0], {(Q_W-1){1'b0}}};
                q_in   = '0;
                den_in = r_den;
            end else begin
                rem_in = r_d1_rem[k-1];
                lo_in  = r_d1_lo[k-1];
                q_in   = r_d1_q[k-1];
                den_in = r_d1_den[k-1];
            end
            t  = {rem_in, lo_in[Q_W-1]};
            ge = t >= {1'b0, den_in};
            n_d1_rem[k] = ge ? D1_REM_W'(t - {1'b0, den_in}) : D1_REM_W'(t);
            n_d1_lo[k]  = lo_in << 1;
            n_d1_q[k]   = {q_in[Q_W-2:0], ge};
            n_d1_den[k] = den_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_d1_rem[k] <= n_d1_rem[k];
                r_d1_lo[k]  <= n_d1_lo[k];
                r_d1_q[k]   <= n_d1_q[k];
                r_d1_den[k] <= n_d1_den[k];
            end
        end
    end

    // ---------------- stage M: magnitude times ratio ----------------
    logic [Q_W-1:0]    w_ratio;
    logic [PROD_W-1:0] r_px;
    logic [PROD_W-1:0] r_py;

    // unit case: ax * 2^29 / root == ax * 1.0(Q17) * 2^12 / root
    assign w_ratio = r_sb[ST_M-1].unit ? R_UNIT : r_d1_q[DIV_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= r_sb[ST_M-1].ax * w_ratio;
            r_py <= r_sb[ST_M-1].ay * w_ratio;
        end
    end

    // ---------------- divider 2: out = prod * 2^12 / root, two lanes ----------------
    logic [D2_REM_W-1:0] r_d2_rem [2][DIV_STEPS];
    logic [Q_W-1:0]      r_d2_lo  [2][DIV_STEPS];
    logic [Q_W-1:0]      r_d2_q   [2][DIV_STEPS];
    logic [D2_REM_W-1:0] n_d2_rem [2][DIV_STEPS];
    logic [Q_W-1:0]      n_d2_lo  [2][DIV_STEPS];
    logic [Q_W-1:0]      n_d2_q   [2][DIV_STEPS];

    always_comb begin
        logic [PROD_W-1:0]   prod;
        logic [D2_REM_W-1:0] rem_in;
        logic [Q_W-1:0]      lo_in;
        logic [Q_W-1:0]      q_in;
        logic [ROOT_W-1:0]   dv;
        logic [D2_REM_W:0]   t;
        logic                ge;
        for (int ln = 0; ln < 2; ln++) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
                prod = (ln == 0) ? r_px : r_py;
                if (k == 0) begin
                    rem_in = D2_REM_W'(prod >> (Q_W - D2_SH));
                    lo_in  = {prod[Q_W-D2_SH-1:0], {D2_SH{1'b0}}};
                    q_in   = '0;
                end else begin
                    rem_in = r_d2_rem[ln][k-1];
                    lo_in  = r_d2_lo[ln][k-1];
                    q_in   = r_d2_q[ln][k-1];
                end
                dv = r_sb[ST_D2+k-1].root;
                t  = {rem_in, lo_in[Q_W-1]};
                ge = t >= {1'b0, dv};
                n_d2_rem[ln][k] = ge ? D2_REM_W'(t - {1'b0, dv}) : D2_REM_W'(t);
                n_d2_lo[ln][k]  = lo_in << 1;
                n_d2_q[ln][k]   = {q_in[Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int ln = 0; ln < 2; ln++) begin
                for (int k = 0; k < DIV_STEPS; k++) begin
                    r_d2_rem[ln][k] <= n_d2_rem[ln][k];
                    r_d2_lo[ln][k]  <= n_d2_lo[ln][k];
                    r_d2_q[ln][k]   <= n_d2_q[ln][k];
                end
            end
        end
    end

    // ---------------- stage F: sign and output register ----------------
    logic [OUT_W-1:0] w_mag_x;
    logic [OUT_W-1:0] w_mag_y;
    logic [OUT_W-1:0] r_out_x;
    logic [OUT_W-1:0] r_out_y;

    assign w_mag_x = r_d2_q[0][DIV_STEPS-1][OUT_W-1:0];
    assign w_mag_y = r_d2_q[1][DIV_STEPS-1][OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_sb[ST_F-1].zero) begin
                r_out_x <= '0;
                r_out_y <= '0;
            end else begin
                r_out_x <= r_sb[ST_F-1].negx ? OUT_W'(-w_mag_x) : w_mag_x;
                r_out_y <= r_sb[ST_F-1].negy ? OUT_W'(-w_mag_y) : w_mag_y;
            end
        end
    end

    assign o_out_x = r_out_x;
    assign o_out_y = r_out_y;

    // ---------------- assertions ----------------
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output stalled");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_E-1] |-> (r_sq_rem[SQ_STEPS-1] <= {1'b0, r_sq_res[SQ_STEPS-1], 1'b0}))
        else $error("square root remainder out of range");

    a_div1_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_M-1] && !r_sb[ST_M-1].zero && !r_sb[ST_M-1].unit)
        |-> (r_d1_rem[DIV_STEPS-1] < r_d1_den[DIV_STEPS-1]))
        else $error("ratio divider remainder not below divisor");

    a_div2_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_F-1] && !r_sb[ST_F-1].zero)
        |-> ((r_d2_rem[0][DIV_STEPS-1] < r_sb[ST_F-1].root)
          && (r_d2_rem[1][DIV_STEPS-1] < r_sb[ST_F-1].root)))
        else $error("output divider remainder not below root");

endmodule
